// File: design/box_non_max_suppression_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for box_non_max_suppression
// Concurrent checks that are active in simulation and empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef BOX_NON_MAX_SUPPRESSION_ASSERT_SVH
`define BOX_NON_MAX_SUPPRESSION_ASSERT_SVH
`ifndef SYNTHESIS
`define BNMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bnms check failed");
`define BNMS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bnms check failed");
`else
`define BNMS_ASSERT(lbl, prop)
`define BNMS_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// File: design/bnms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnms_pkg
// Shared types, widths and edge helpers of the box suppression block.
// ----------------------------------------------------------------------------
package bnms_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned AREA_W  = 32;
  localparam int unsigned EDGE_W  = 19;  // signed, twice the coordinate scale
  localparam int unsigned DIM_W   = 18;  // clamped overlap extent
  localparam int unsigned INTER_W = 2 * DIM_W;
  localparam int unsigned UNI_W   = INTER_W + 1;  // signed union
  localparam int unsigned PROD_W  = INTER_W + 16;
  localparam int unsigned IOU_LAT = 4;

  // one ranked box as it travels along the ring
  typedef struct packed {
    logic               valid;
    logic               supp;
    logic [IDX_W-1:0]   idx;
    logic [SCORE_W-1:0] score;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [AREA_W-1:0]  area;
  } box_t;

  // kept reference box
  typedef struct packed {
    logic signed [EDGE_W-1:0] l;
    logic signed [EDGE_W-1:0] r;
    logic signed [EDGE_W-1:0] t;
    logic signed [EDGE_W-1:0] d;
    logic [AREA_W-1:0]        area;
  } ref_t;

  function automatic logic signed [EDGE_W-1:0] lo_edge(logic [COORD_W-1:0] c,
                                                      logic [COORD_W-1:0] s);
    return $signed({2'b00, c, 1'b0}) - $signed({3'b000, s});
  endfunction

  function automatic logic signed [EDGE_W-1:0] hi_edge(logic [COORD_W-1:0] c,
                                                      logic [COORD_W-1:0] s);
    return $signed({2'b00, c, 1'b0}) + $signed({3'b000, s});
  endfunction

endpackage

// File: design/bnms_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnms_cell
// One slot of the ranking chain: sorted insert on load, shift on selection.
// ----------------------------------------------------------------------------
module bnms_cell import bnms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic ins_i,      // insert new box
  input  logic shift_i,    // ring shift toward head
  input  box_t new_i,
  input  box_t prev_i,     // neighbor closer to head
  input  box_t next_i,     // neighbor farther from head
  input  logic gt_prev_i,  // new box ranks above neighbor closer to head
  output logic gt_o,
  output box_t ent_o
);

  box_t ent_q, ent_d;

  // equal score keeps the stored (earlier loaded) box ahead
  assign gt_o = !ent_q.valid || (new_i.score > ent_q.score);

  always_comb begin
    ent_d = ent_q;
    if (shift_i) begin
      ent_d = next_i;
    end else if (ins_i) begin
      if (gt_prev_i) begin
        ent_d = prev_i;
      end else if (gt_o) begin
        ent_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

// File: design/bnms_iou.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnms_iou
// Four-stage overlap pipeline closing the ring; marks boxes the kept box hides.
// ----------------------------------------------------------------------------
module bnms_iou import bnms_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         cmp_i,
  input  box_t         box_i,
  input  ref_t         ref_i,
  input  logic [15:0]  thr_i,
  output box_t         box_o,
  output logic         busy_o
);

  box_t                      b0_q, b1_q, b2_q, b3_q;
  logic                      c0_q, c1_q, c2_q, c3_q;
  logic [DIM_W-1:0]          iw_q, ih_q;
  logic [INTER_W-1:0]        in1_q, in2_q, in3_q;
  logic signed [UNI_W-1:0]   uni_q;
  logic [PROD_W-1:0]         prod_q;
  logic                      upos_q;

  logic signed [EDGE_W-1:0]  bl, br, bt, bd, x1, x2, y1, y2;
  logic signed [EDGE_W:0]    dx, dy;
  logic [DIM_W-1:0]          iw_d, ih_d;
  logic signed [UNI_W-1:0]   uni_d;
  logic                      hit;

  always_comb begin
    bl = lo_edge(box_i.cx, box_i.w);
    br = hi_edge(box_i.cx, box_i.w);
    bt = lo_edge(box_i.cy, box_i.h);
    bd = hi_edge(box_i.cy, box_i.h);
    x1 = (ref_i.l > bl) ? ref_i.l : bl;
    x2 = (ref_i.r < br) ? ref_i.r : br;
    y1 = (ref_i.t > bt) ? ref_i.t : bt;
    y2 = (ref_i.d < bd) ? ref_i.d : bd;
    dx = $signed({x2[EDGE_W-1], x2}) - $signed({x1[EDGE_W-1], x1});
    dy = $signed({y2[EDGE_W-1], y2}) - $signed({y1[EDGE_W-1], y1});
    iw_d = (dx > 0) ? dx[DIM_W-1:0] : '0;
    ih_d = (dy > 0) ? dy[DIM_W-1:0] : '0;
    uni_d = $signed({3'b000, ref_i.area, 2'b00}) + $signed({3'b000, b1_q.area, 2'b00})
          - $signed({1'b0, in1_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= '0;
      b1_q <= '0;
      b2_q <= '0;
      b3_q <= '0;
    end else if (en_i) begin
      b0_q <= box_i;
      b1_q <= b0_q;
      b2_q <= b1_q;
      b3_q <= b2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c0_q <= cmp_i;  c1_q <= c0_q;  c2_q <= c1_q;  c3_q <= c2_q;
      iw_q   <= iw_d;
      ih_q   <= ih_d;
      in1_q  <= iw_q * ih_q;
      in2_q  <= in1_q;
      uni_q  <= uni_d;
      in3_q  <= in2_q;
      prod_q <= thr_i * uni_q[INTER_W-1:0];
      upos_q <= !uni_q[UNI_W-1] && (uni_q != '0);
    end
  end

  assign hit = c3_q && b3_q.valid && upos_q && ({in3_q, 16'h0000} > prod_q);

  always_comb begin
    box_o      = b3_q;
    box_o.supp = b3_q.supp || hit;
  end

  assign busy_o = b0_q.valid || b1_q.valid || b2_q.valid || b3_q.valid;

endmodule

// File: design/box_non_max_suppression.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_non_max_suppression
// Greedy IoU non-maximum suppression over up to MAX_BOXES detection boxes.
// ----------------------------------------------------------------------------
// Boxes are taken one per cycle and sorted on arrival into a chain of
// MAX_BOXES cells, highest score at the head, ties kept in load order. The
// request with tlast set starts selection. The chain and a 4-stage IoU
// pipeline form a ring of MAX_BOXES+4 slots. Each step of selection looks at
// the head box: a box below the score floor or already suppressed is dropped;
// a kept box is dropped from the ring and the ring turns once more so every
// remaining box passes the IoU unit and is marked when its overlap with the
// kept box is above the threshold. The shared IoU unit sets the rate: each
// kept box costs a full turn of the ring, and loading, dropped boxes, the
// closing result and a stalled output register add to it. No new box is
// taken until the final result is in the output register.
// ----------------------------------------------------------------------------
module box_non_max_suppression import bnms_pkg::*; #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // box in; tdata: center_x, center_y, box_w, box_h, confidence
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // final_box
  // result out; tdata: kept_index, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // any_kept, overflowed
  output logic        m_axis_tlast,   // end_of_list
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned RING   = MAX_BOXES + IOU_LAT;
  localparam int unsigned CNT_W  = $clog2(MAX_BOXES + 1);
  localparam int unsigned PASS_W = $clog2(RING + 1);
  localparam logic REG_THR   = 1'b0;
  localparam logic REG_FLOOR = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_PICK = 4'b0010,
    ST_PASS = 4'b0100,
    ST_LAST = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d, rem_q, rem_d;
  logic [PASS_W-1:0]   pass_q, pass_d;
  logic                ovf_q, ovf_d;
  logic                pend_v_q, pend_v_d;
  logic [IDX_W-1:0]    pend_idx_q, pend_idx_d;
  ref_t                ref_q, ref_d;
  logic [15:0]         thr_q, floor_q;

  logic                out_v_q, out_any_q, out_ovf_q, out_last_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic                out_free, push, push_any, push_last;
  logic [IDX_W-1:0]    push_idx;

  box_t                new_box, head_in, ring_tail;
  box_t                ent [MAX_BOXES];
  logic                gt [MAX_BOXES];
  logic                ins, shift, kill, cmp, iou_busy, in_acc, keep;

  // register port
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= 16'd16384;
      floor_q <= 16'd22938;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_THR:   thr_q   <= pwdata[15:0];
        REG_FLOOR: floor_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THR:   prdata = {16'h0000, thr_q};
      REG_FLOOR: prdata = {16'h0000, floor_q};
      default:   prdata = '0;
    endcase
  end

  // incoming box
  always_comb begin
    new_box.valid = 1'b1;
    new_box.supp  = 1'b0;
    new_box.idx   = IDX_W'(cnt_q);
    new_box.cx    = s_axis_tdata[15:0];
    new_box.cy    = s_axis_tdata[31:16];
    new_box.w     = s_axis_tdata[47:32];
    new_box.h     = s_axis_tdata[63:48];
    new_box.score = s_axis_tdata[79:64];
    new_box.area  = s_axis_tdata[47:32] * s_axis_tdata[63:48];
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ranking chain
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    bnms_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ins_i    (ins),
      .shift_i  (shift),
      .new_i    (new_box),
      .prev_i   ((i == 0) ? new_box : ent[(i == 0) ? 0 : i - 1]),
      .next_i   ((i == MAX_BOXES - 1) ? ring_tail : ent[(i == MAX_BOXES - 1) ? i : i + 1]),
      .gt_prev_i((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .gt_o     (gt[i]),
      .ent_o    (ent[i])
    );
  end

  always_comb begin
    head_in = ent[0];
    if (kill) head_in.valid = 1'b0;
  end

  bnms_iou u_iou (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (shift),
    .cmp_i  (cmp),
    .box_i  (head_in),
    .ref_i  (ref_q),
    .thr_i  (thr_q),
    .box_o  (ring_tail),
    .busy_o (iou_busy)
  );

  // selection control
  assign out_free = !out_v_q || m_axis_tready;
  assign keep     = (ent[0].score >= floor_q) && !ent[0].supp;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    pass_d     = pass_q;
    ovf_d      = ovf_q;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    ref_d      = ref_q;
    ins        = 1'b0;
    shift      = 1'b0;
    kill       = 1'b0;
    cmp        = 1'b0;
    push       = 1'b0;
    push_idx   = pend_idx_q;
    push_any   = 1'b1;
    push_last  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_q < CNT_W'(MAX_BOXES)) begin
            ins   = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            rem_d   = cnt_d;
            state_d = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        if (rem_q == '0) begin
          state_d = ST_LAST;
        end else if (!keep) begin
          shift = 1'b1;
          kill  = 1'b1;
          rem_d = rem_q - 1'b1;
        end else if (!pend_v_q || out_free) begin
          push       = pend_v_q;
          pend_v_d   = 1'b1;
          pend_idx_d = ent[0].idx;
          ref_d.l    = lo_edge(ent[0].cx, ent[0].w);
          ref_d.r    = hi_edge(ent[0].cx, ent[0].w);
          ref_d.t    = lo_edge(ent[0].cy, ent[0].h);
          ref_d.d    = hi_edge(ent[0].cy, ent[0].h);
          ref_d.area = ent[0].area;
          shift      = 1'b1;
          kill       = 1'b1;
          rem_d      = rem_q - 1'b1;
          pass_d     = PASS_W'(RING);
          state_d    = ST_PASS;
        end
      end
      ST_PASS: begin
        shift  = 1'b1;
        cmp    = 1'b1;
        pass_d = pass_q - 1'b1;
        if (pass_q == PASS_W'(1)) state_d = ST_PICK;
      end
      ST_LAST: begin
        if (out_free) begin
          push      = 1'b1;
          push_idx  = pend_v_q ? pend_idx_q : '0;
          push_any  = pend_v_q;
          push_last = 1'b1;
          pend_v_d  = 1'b0;
          cnt_d     = '0;
          ovf_d     = 1'b0;
          state_d   = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      rem_q    <= '0;
      pass_q   <= '0;
      ovf_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      pass_q   <= pass_d;
      ovf_q    <= ovf_d;
      pend_v_q <= pend_v_d;
      if (push)               out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    ref_q      <= ref_d;
    if (push) begin
      out_idx_q  <= push_idx;
      out_any_q  <= push_any;
      out_ovf_q  <= ovf_q;
      out_last_q <= push_last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(8 - IDX_W){1'b0}}, out_idx_q};
  assign m_axis_tuser  = {out_ovf_q, out_any_q};
  assign m_axis_tlast  = out_last_q;

`include "box_non_max_suppression_assert.svh"

  `BNMS_ASSERT(a_cnt_cap, cnt_q <= CNT_W'(MAX_BOXES))
  `BNMS_ASSERT_IMPL(a_load_ring_idle, state_q == ST_LOAD, !iou_busy)
  `BNMS_ASSERT_IMPL(a_pass_has_pending, state_q == ST_PASS, pend_v_q)
  `BNMS_ASSERT_IMPL(a_rem_le_cnt, state_q == ST_PICK, rem_q <= cnt_q)

endmodule
